@@ rtl/rawi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rawi_pkg
// Shared types, widths, codes and reset values of the ray to arena wall
// intersection unit.
// ----------------------------------------------------------------------------
package rawi_pkg;

  localparam int NUM_REGS  = 6;
  localparam int NUM_WALLS = 4;
  localparam int NUM_AXES  = 3;
  localparam int NUM_OFF   = 2;   // divided offsets per wall (the two other axes)

  localparam int COORD_W = 32;    // Q16.16 coordinate
  localparam int DIFF_W  = 33;    // difference of two coordinates
  localparam int PROD_W  = 65;    // magnitude of a product of two differences

  // Rounding divider: 42 quotient bits, three per stage
  localparam int QUOT_W    = 42;
  localparam int DIV_HI_W  = PROD_W - QUOT_W;
  localparam int OFF_W     = 41;
  localparam logic [OFF_W-1:0] OFF_CAP = {1'b1, {(OFF_W-1){1'b0}}};
  localparam int DIV_STEPS = 3;
  localparam int DIV_STG   = QUOT_W / DIV_STEPS;
  localparam int DIV_LAT   = DIV_STG + 2;

  // Rounding square root: 32 root bits, two per stage
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 33;
  localparam int SQ_STEPS = 2;
  localparam int SQ_STG   = (RAD_W / 2) / SQ_STEPS;
  localparam int SQ_LAT   = SQ_STG + 2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_X_MIN = 3'd0,
    REG_X_MAX = 3'd1,
    REG_Y_MIN = 3'd2,
    REG_Y_MAX = 3'd3,
    REG_Z_MIN = 3'd4,
    REG_Z_MAX = 3'd5
  } reg_idx_e;

  localparam logic signed [COORD_W-1:0] REG_RESET [NUM_REGS] = '{
    -32'sd131072, 32'sd131072, -32'sd131072, 32'sd131072, 32'sd0, 32'sd65536
  };

  // Opcodes
  localparam logic [2:0] OP_NEAREST = 3'd0;
  localparam logic [2:0] OP_X_MIN   = 3'd1;
  localparam logic [2:0] OP_X_MAX   = 3'd2;
  localparam logic [2:0] OP_Y_MIN   = 3'd3;
  localparam logic [2:0] OP_Y_MAX   = 3'd4;
  localparam logic [2:0] FORCE_OP [NUM_WALLS] = '{OP_X_MIN, OP_X_MAX, OP_Y_MIN, OP_Y_MAX};

  // Wall index codes
  localparam logic [1:0] WALL_X_MIN = 2'd0;
  localparam logic [1:0] WALL_X_MAX = 2'd1;
  localparam logic [1:0] WALL_Y_MIN = 2'd2;
  localparam logic [1:0] WALL_Y_MAX = 2'd3;

endpackage

@@ rtl/ray_to_arena_wall_intersect_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_to_arena_wall_intersect_unit
// Intersects a ray with four axis-aligned arena walls, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Takes one ray per clock while the output is not stalled and returns one
// result per ray, in order. The pipeline runs through the rounding dividers
// (42 quotient bits, three per stage) and the rounding square root (32 root
// bits, two per stage); all four walls are worked in parallel, each with two
// dividers and one square root. A stalled output holds the whole pipeline.
// The user must write wall registers through the cfg port only while no ray
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ray_to_arena_wall_intersect_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  // ray stream
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // origin_x, origin_y, origin_z, through_x, through_y, through_z
  input  logic [191:0]  s_axis_tdata_i,
  // opcode
  input  logic [2:0]    s_axis_tuser_i,
  // result stream
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // wall_index, hit_x, hit_y, hit_z, hit_distance, zero pad
  output logic [135:0]  m_axis_tdata_o,
  // found
  output logic          m_axis_tuser_o
);

  localparam int NW  = rawi_pkg::NUM_WALLS;
  localparam int NA  = rawi_pkg::NUM_AXES;
  localparam int CW  = rawi_pkg::COORD_W;
  localparam int DW  = rawi_pkg::DIFF_W;
  localparam int DL  = rawi_pkg::DIV_LAT;
  localparam int SL  = rawi_pkg::SQ_LAT;
  localparam int HW  = 43;

  function automatic logic [DW-1:0] mag33(input logic [DW-1:0] v);
    return v[DW-1] ? (DW'(0) - v) : v;
  endfunction

  function automatic logic [CW-1:0] sat32(input logic signed [HW-1:0] v);
    if (v > 43'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -43'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[CW-1:0];
  endfunction

  logic en;
  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // --------------------------------------------------------------------------
  // Wall registers
  logic signed [CW-1:0] wall_q [rawi_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rawi_pkg::NUM_REGS; i++) wall_q[i] <= rawi_pkg::REG_RESET[i];
    end else if (cfg_we_i && (cfg_index_i < 3'(rawi_pkg::NUM_REGS))) begin
      wall_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits along the pipeline
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic vdiv_q [DL];
  logic vsq_q  [SL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DL; i++) vdiv_q[i] <= 1'b0;
      for (int i = 0; i < SL; i++) vsq_q[i] <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      vdiv_q[0] <= v2_q;
      for (int i = 1; i < DL; i++) vdiv_q[i] <= vdiv_q[i-1];
      v3_q <= vdiv_q[DL-1];
      v4_q <= v3_q;
      v5_q <= v4_q;
      vsq_q[0] <= v5_q;
      for (int i = 1; i < SL; i++) vsq_q[i] <= vsq_q[i-1];
      out_valid_q <= vsq_q[SL-1];
    end
  end

  // --------------------------------------------------------------------------
  // Shared payload: opcode, origin and direction
  logic [2:0]    op1_q, op2_q;
  logic [CW-1:0] o1_q [NA];
  logic [CW-1:0] o2_q [NA];
  logic [DW-1:0] d1_q [NA];
  logic [2:0]    opd_q [DL];
  logic [NA-1:0][CW-1:0] od_q [DL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= s_axis_tuser_i;
      for (int j = 0; j < NA; j++) begin
        o1_q[j] <= s_axis_tdata_i[CW*j +: CW];
        d1_q[j] <= {s_axis_tdata_i[CW*(j+NA)+CW-1], s_axis_tdata_i[CW*(j+NA) +: CW]}
                 - {s_axis_tdata_i[CW*j+CW-1], s_axis_tdata_i[CW*j +: CW]};
        o2_q[j] <= o1_q[j];
        od_q[0][j] <= o2_q[j];
      end
      op2_q <= op1_q;
      opd_q[0] <= op2_q;
      for (int i = 1; i < DL; i++) begin
        opd_q[i] <= opd_q[i-1];
        od_q[i]  <= od_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Per-wall datapath
  logic [CW-1:0]         dist_w [NW];
  logic                  elig_w [NW];
  logic [NA-1:0][CW-1:0] hit_w  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_wall
    localparam int AX  = (k < 2) ? 0 : 1;      // wall normal axis
    localparam int OTH = (k < 2) ? 1 : 0;      // in-plane span axis
    localparam int SLO = (k < 2) ? int'(rawi_pkg::REG_Y_MIN) : int'(rawi_pkg::REG_X_MIN);
    localparam int SHI = (k < 2) ? int'(rawi_pkg::REG_Y_MAX) : int'(rawi_pkg::REG_X_MAX);

    logic [DW-1:0]                 num_q;
    logic [rawi_pkg::PROD_W-1:0]   prod_q [rawi_pkg::NUM_OFF];
    logic [DW-1:0]                 den_q, mnum_q;
    logic                          ok_q;
    logic [1:0]                    neg_q;
    logic                          okd_q   [DL];
    logic [1:0]                    negd_q  [DL];
    logic [DW-1:0]                 mnumd_q [DL];
    logic [rawi_pkg::OFF_W-1:0]    quot   [rawi_pkg::NUM_OFF];

    // Stage 1: distance from origin to the wall plane
    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q <= {wall_q[k][CW-1], wall_q[k]}
               - {s_axis_tdata_i[CW*AX+CW-1], s_axis_tdata_i[CW*AX +: CW]};
      end
    end

    // Stage 2: offset products and miss test
    always_ff @(posedge clk_i) begin
      if (en) begin
        prod_q[0] <= rawi_pkg::PROD_W'(mag33(num_q)) * rawi_pkg::PROD_W'(mag33(d1_q[OTH]));
        prod_q[1] <= rawi_pkg::PROD_W'(mag33(num_q)) * rawi_pkg::PROD_W'(mag33(d1_q[2]));
        den_q  <= mag33(d1_q[AX]);
        mnum_q <= mag33(num_q);
        ok_q   <= (d1_q[AX] != '0) && (num_q != '0) && (num_q[DW-1] == d1_q[AX][DW-1]);
        neg_q  <= {d1_q[2][DW-1], d1_q[OTH][DW-1]};
      end
    end

    for (genvar i = 0; i < rawi_pkg::NUM_OFF; i++) begin : g_div
      rawi_div u_div (
        .clk_i  (clk_i),
        .en_i   (en),
        .prod_i (prod_q[i]),
        .den_i  (den_q),
        .quot_o (quot[i])
      );
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        okd_q[0]   <= ok_q;
        negd_q[0]  <= neg_q;
        mnumd_q[0] <= mnum_q;
        for (int i = 1; i < DL; i++) begin
          okd_q[i]   <= okd_q[i-1];
          negd_q[i]  <= negd_q[i-1];
          mnumd_q[i] <= mnumd_q[i-1];
        end
      end
    end

    // Stage 3: hit point, limit check, eligibility, offset magnitudes
    logic signed [HW-1:0]  hit0, hit1, wl_lo, wl_hi, wz_lo, wz_hi;
    logic                  in_lim, elig_d, big_d;
    logic [NA-1:0][CW-1:0] hit_d;

    always_comb begin
      logic signed [HW-1:0] off0, off1;
      off0 = negd_q[DL-1][0] ? -HW'(quot[0]) : HW'(quot[0]);
      off1 = negd_q[DL-1][1] ? -HW'(quot[1]) : HW'(quot[1]);
      hit0 = HW'($signed(od_q[DL-1][OTH])) + off0;
      hit1 = HW'($signed(od_q[DL-1][2])) + off1;
      wl_lo = HW'(wall_q[SLO]);
      wl_hi = HW'(wall_q[SHI]);
      wz_lo = HW'(wall_q[rawi_pkg::REG_Z_MIN]);
      wz_hi = HW'(wall_q[rawi_pkg::REG_Z_MAX]);
      in_lim = (hit1 >= wz_lo) && (hit1 <= wz_hi) && (hit0 >= wl_lo) && (hit0 <= wl_hi);
      if (opd_q[DL-1] == rawi_pkg::OP_NEAREST) begin
        elig_d = okd_q[DL-1] && in_lim;
      end else begin
        elig_d = okd_q[DL-1] && (opd_q[DL-1] == rawi_pkg::FORCE_OP[k]);
      end
      big_d = mnumd_q[DL-1][DW-1] || (quot[0][rawi_pkg::OFF_W-1:CW] != '0)
           || (quot[1][rawi_pkg::OFF_W-1:CW] != '0);
      hit_d[AX]  = wall_q[k];
      hit_d[OTH] = sat32(hit0);
      hit_d[2]   = sat32(hit1);
    end

    logic                  elig3_q, big3_q, elig4_q, big4_q, elig5_q, sat5_q;
    logic [NA-1:0][CW-1:0] hit3_q, hit4_q, hit5_q;
    logic [CW-1:0]         m3_q  [NA];
    logic [2*CW-1:0]       sq4_q [NA];
    logic [rawi_pkg::RAD_W-1:0] rad5_q;
    logic [rawi_pkg::RAD_W+1:0] sum;

    assign sum = (rawi_pkg::RAD_W+2)'(sq4_q[0]) + (rawi_pkg::RAD_W+2)'(sq4_q[1])
               + (rawi_pkg::RAD_W+2)'(sq4_q[2]);

    // Stages 3 to 5: register hit, square offsets, sum squares
    always_ff @(posedge clk_i) begin
      if (en) begin
        elig3_q <= elig_d;
        big3_q  <= big_d;
        hit3_q  <= hit_d;
        m3_q[0] <= mnumd_q[DL-1][CW-1:0];
        m3_q[1] <= quot[0][CW-1:0];
        m3_q[2] <= quot[1][CW-1:0];
        for (int j = 0; j < NA; j++) sq4_q[j] <= (2*CW)'(m3_q[j]) * (2*CW)'(m3_q[j]);
        elig4_q <= elig3_q;
        big4_q  <= big3_q;
        hit4_q  <= hit3_q;
        rad5_q  <= sum[rawi_pkg::RAD_W-1:0];
        sat5_q  <= big4_q || (sum[rawi_pkg::RAD_W+1:rawi_pkg::RAD_W] != '0);
        elig5_q <= elig4_q;
        hit5_q  <= hit4_q;
      end
    end

    logic [rawi_pkg::ROOT_W-1:0] root;

    rawi_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (rad5_q),
      .root_o (root)
    );

    logic                  eligs_q [SL];
    logic                  sats_q  [SL];
    logic [NA-1:0][CW-1:0] hits_q  [SL];

    always_ff @(posedge clk_i) begin
      if (en) begin
        eligs_q[0] <= elig5_q;
        sats_q[0]  <= sat5_q;
        hits_q[0]  <= hit5_q;
        for (int i = 1; i < SL; i++) begin
          eligs_q[i] <= eligs_q[i-1];
          sats_q[i]  <= sats_q[i-1];
          hits_q[i]  <= hits_q[i-1];
        end
      end
    end

    assign dist_w[k] = (sats_q[SL-1] || root[rawi_pkg::ROOT_W-1]) ? '1
                                                                   : root[CW-1:0];
    assign elig_w[k] = eligs_q[SL-1];
    assign hit_w[k]  = hits_q[SL-1];
  end

  // --------------------------------------------------------------------------
  // Nearest eligible wall; ties keep the lower index
  logic          pick01, pick23, pick_hi, elig_lo, elig_hi, found_d;
  logic [1:0]    idx_lo, idx_hi, idx_d;
  logic [CW-1:0] dist_lo, dist_hi, dist_d;

  always_comb begin
    pick01  = elig_w[1] && (!elig_w[0] || (dist_w[1] < dist_w[0]));
    pick23  = elig_w[3] && (!elig_w[2] || (dist_w[3] < dist_w[2]));
    idx_lo  = pick01 ? rawi_pkg::WALL_X_MAX : rawi_pkg::WALL_X_MIN;
    idx_hi  = pick23 ? rawi_pkg::WALL_Y_MAX : rawi_pkg::WALL_Y_MIN;
    dist_lo = pick01 ? dist_w[1] : dist_w[0];
    dist_hi = pick23 ? dist_w[3] : dist_w[2];
    elig_lo = elig_w[0] || elig_w[1];
    elig_hi = elig_w[2] || elig_w[3];
    pick_hi = elig_hi && (!elig_lo || (dist_hi < dist_lo));
    idx_d   = pick_hi ? idx_hi : idx_lo;
    dist_d  = pick_hi ? dist_hi : dist_lo;
    found_d = elig_lo || elig_hi;
  end

  // Output register
  logic          found_q;
  logic [1:0]    widx_q;
  logic [CW-1:0] hx_q, hy_q, hz_q, hd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      found_q <= found_d;
      widx_q  <= found_d ? idx_d : '0;
      hx_q    <= found_d ? hit_w[idx_d][0] : '0;
      hy_q    <= found_d ? hit_w[idx_d][1] : '0;
      hz_q    <= found_d ? hit_w[idx_d][2] : '0;
      hd_q    <= found_d ? dist_d : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = found_q;
  assign m_axis_tdata_o  = {6'b0, hd_q, hz_q, hy_q, hx_q, widx_q};

  // --------------------------------------------------------------------------
  // Assertions

  // A miss carries all-zero result fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("miss transaction with non-zero result fields");

  // A held result blocks new transactions
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while the output is stalled");

  // A stalled result stays put through the next cycle
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(hd_q)))
    else $error("stalled result lost or changed");

endmodule

@@ rtl/rawi_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rawi_div
// Pipelined restoring divider, product / divisor rounded to nearest (ties
// away from zero), quotient clamped at 2^40.
// ----------------------------------------------------------------------------
module rawi_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [rawi_pkg::PROD_W-1:0]  prod_i,
  input  logic [rawi_pkg::DIFF_W-1:0]  den_i,
  output logic [rawi_pkg::OFF_W-1:0]   quot_o
);

  localparam int NS = rawi_pkg::DIV_STG;
  localparam int DW = rawi_pkg::DIFF_W;
  localparam int QW = rawi_pkg::QUOT_W;

  logic [DW-1:0] rem_q [NS+1];
  logic [DW-1:0] rem_d [NS+1];
  logic [QW-1:0] low_q [NS+1];
  logic [QW-1:0] low_d [NS+1];
  logic [QW-1:0] quo_q [NS+1];
  logic [QW-1:0] quo_d [NS+1];
  logic [DW-1:0] den_q [NS+1];
  logic          ovf_q [NS+1];
  logic          ovf_d [NS+1];
  logic [rawi_pkg::OFF_W-1:0] quot_q, quot_d;

  // Entry: top bits form the first partial remainder, overflow if they reach the divisor
  always_comb begin
    rem_d[0] = DW'(prod_i[rawi_pkg::PROD_W-1 -: rawi_pkg::DIV_HI_W]);
    ovf_d[0] = DW'(prod_i[rawi_pkg::PROD_W-1 -: rawi_pkg::DIV_HI_W]) >= den_i;
    low_d[0] = prod_i[QW-1:0];
    quo_d[0] = '0;
  end

  // Iteration stages, DIV_STEPS quotient bits each
  for (genvar s = 1; s <= NS; s++) begin : g_stage
    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [QW-1:0] l;
      logic [QW-1:0] q;
      r = rem_q[s-1];
      l = low_q[s-1];
      q = quo_q[s-1];
      for (int k = 0; k < rawi_pkg::DIV_STEPS; k++) begin
        t = {r, l[QW-1]};
        l = {l[QW-2:0], 1'b0};
        if (t >= {1'b0, den_q[s-1]}) begin
          t = t - {1'b0, den_q[s-1]};
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
        r = t[DW-1:0];
      end
      rem_d[s] = r;
      low_d[s] = l;
      quo_d[s] = q;
      ovf_d[s] = ovf_q[s-1];
    end
  end

  // Rounding and clamp
  always_comb begin
    logic          up;
    logic [QW:0]   qr;
    up = {rem_q[NS], 1'b0} >= {1'b0, den_q[NS]};
    qr = {1'b0, quo_q[NS]} + (QW+1)'(up);
    if (ovf_q[NS] || (qr > (QW+1)'(rawi_pkg::OFF_CAP))) begin
      quot_d = rawi_pkg::OFF_CAP;
    end else begin
      quot_d = qr[rawi_pkg::OFF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      low_q[0] <= low_d[0];
      quo_q[0] <= quo_d[0];
      ovf_q[0] <= ovf_d[0];
      den_q[0] <= den_i;
      for (int s = 1; s <= NS; s++) begin
        rem_q[s] <= rem_d[s];
        low_q[s] <= low_d[s];
        quo_q[s] <= quo_d[s];
        ovf_q[s] <= ovf_d[s];
        den_q[s] <= den_q[s-1];
      end
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

@@ rtl/rawi_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rawi_sqrt
// Pipelined digit-by-digit integer square root of a 64-bit radicand, rounded
// to nearest.
// ----------------------------------------------------------------------------
module rawi_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [rawi_pkg::RAD_W-1:0]   rad_i,
  output logic [rawi_pkg::ROOT_W-1:0]  root_o
);

  localparam int NS = rawi_pkg::SQ_STG;
  localparam int RW = rawi_pkg::RAD_W;

  logic [RW-1:0] s_q [NS+1];
  logic [RW-1:0] s_d [NS+1];
  logic [RW-1:0] r_q [NS+1];
  logic [RW-1:0] r_d [NS+1];
  logic [rawi_pkg::ROOT_W-1:0] root_q, root_d;

  assign s_d[0] = rad_i;
  assign r_d[0] = '0;

  // Two root digits per stage
  for (genvar st = 1; st <= NS; st++) begin : g_stage
    always_comb begin
      logic [RW-1:0] s;
      logic [RW-1:0] r;
      logic [RW-1:0] b;
      s = s_q[st-1];
      r = r_q[st-1];
      for (int k = 0; k < rawi_pkg::SQ_STEPS; k++) begin
        b = RW'(1) << (RW - 2 - 2 * ((st - 1) * rawi_pkg::SQ_STEPS + k));
        if (s >= r + b) begin
          s = s - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      s_d[st] = s;
      r_d[st] = r;
    end
  end

  // Round up when the remainder exceeds the root
  always_comb begin
    root_d = {1'b0, r_q[NS][rawi_pkg::ROOT_W-2:0]}
           + rawi_pkg::ROOT_W'(s_q[NS] > r_q[NS]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int st = 0; st <= NS; st++) begin
        s_q[st] <= s_d[st];
        r_q[st] <= r_d[st];
      end
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

@@ tb/tb_ray_to_arena_wall_intersect_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray to arena wall intersection unit testbench
// Drives rays with random handshake gaps on both streams, predicts every
// intersection result from the wall registers, and compares each returned
// transaction field by field. Wall settings change between phases, once
// the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_ray_to_arena_wall_intersect_unit;

  typedef struct {
    logic [2:0]         opcode;
    logic signed [31:0] orig [3];
    logic signed [31:0] thru [3];
  } ray_t;

  typedef struct {
    logic        found;
    logic [1:0]  wall;
    logic [31:0] hx;
    logic [31:0] hy;
    logic [31:0] hz;
    logic [31:0] hdist;
  } hit_t;

  // Intersection predictor and store of expected hits
  class wall_hit_scoreboard;
    logic signed [63:0] wall_reg [rawi_pkg::NUM_REGS];
    hit_t               pending_q [$];
    int                 errors;

    function new();
      for (int i = 0; i < rawi_pkg::NUM_REGS; i++) wall_reg[i] = rawi_pkg::REG_RESET[i];
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] v);
      wall_reg[idx] = $signed(v);
    endfunction

    static function logic [63:0] mag(logic signed [63:0] v);
      return v < 0 ? -v : v;
    endfunction

    // a*b/c rounded half away from zero, magnitude held at OFF_CAP
    static function logic signed [63:0] scale_div(logic signed [63:0] a,
        logic signed [63:0] b, logic signed [63:0] c);
      logic [127:0] p, q, r, uc;
      logic         neg;
      neg = ((a < 0) != (b < 0)) != (c < 0);
      uc = {64'd0, mag(c)};
      p = {64'd0, mag(a)} * {64'd0, mag(b)};
      q = p / uc;
      r = p % uc;
      if (q <= 128'(rawi_pkg::OFF_CAP) && r >= uc - r) q = q + 1;
      if (q > 128'(rawi_pkg::OFF_CAP)) q = 128'(rawi_pkg::OFF_CAP);
      return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    static function logic [63:0] root_round(logic [63:0] s);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s = s - (r + b);
          r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      if (s > r) r = r + 1;
      return r;
    endfunction

    static function logic [31:0] dist_of(logic signed [63:0] off [3]);
      logic [65:0] sum;
      logic [63:0] m, rt;
      sum = 0;
      for (int j = 0; j < 3; j++) begin
        m = mag(off[j]);
        if (m > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        sum = sum + 66'(m * m);
        if (sum[65:64] != 0) return 32'hFFFF_FFFF;
      end
      rt = root_round(sum[63:0]);
      return rt > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : rt[31:0];
    endfunction

    static function logic [31:0] sat(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function bit wall_hit(int k, logic signed [63:0] o [3], logic signed [63:0] d [3],
        output logic signed [63:0] pt [3], output logic signed [63:0] off [3]);
      int                 ax;
      logic signed [63:0] num;
      ax = k < 2 ? 0 : 1;
      num = wall_reg[k] - o[ax];
      if (d[ax] == 0 || num == 0 || ((num < 0) != (d[ax] < 0))) return 0;
      for (int j = 0; j < 3; j++) begin
        if (j == ax) off[j] = num;
        else if (d[j] == 0) off[j] = 0;
        else off[j] = scale_div(num, d[j], d[ax]);
        pt[j] = o[j] + off[j];
      end
      return 1;
    endfunction

    function bit in_limits(int k, logic signed [63:0] pt [3]);
      if (pt[2] < wall_reg[rawi_pkg::REG_Z_MIN] || pt[2] > wall_reg[rawi_pkg::REG_Z_MAX])
        return 0;
      if (k < 2)
        return pt[1] >= wall_reg[rawi_pkg::REG_Y_MIN] && pt[1] <= wall_reg[rawi_pkg::REG_Y_MAX];
      return pt[0] >= wall_reg[rawi_pkg::REG_X_MIN] && pt[0] <= wall_reg[rawi_pkg::REG_X_MAX];
    endfunction

    // Accepted ray: work out and queue its hit
    function void note_ray(ray_t ray);
      logic signed [63:0] o [3], d [3], pt [3], off [3], best [3];
      logic [31:0]        bd, dd;
      int                 bk;
      bit                 fnd;
      hit_t               h;
      fnd = 0;
      bk = 0;
      bd = 0;
      for (int j = 0; j < 3; j++) begin
        o[j] = ray.orig[j];
        d[j] = 64'(ray.thru[j]) - o[j];
        best[j] = 0;
      end
      if (ray.opcode == rawi_pkg::OP_NEAREST) begin
        for (int k = 0; k < rawi_pkg::NUM_WALLS; k++) begin
          if (!wall_hit(k, o, d, pt, off)) continue;
          if (!in_limits(k, pt)) continue;
          dd = dist_of(off);
          if (!fnd || dd < bd) begin
            fnd = 1;
            bk = k;
            bd = dd;
            best = pt;
          end
        end
      end else if (ray.opcode <= rawi_pkg::OP_Y_MAX) begin
        bk = ray.opcode - 1;
        if (wall_hit(bk, o, d, pt, off)) begin
          fnd = 1;
          bd = dist_of(off);
          best = pt;
        end
      end
      h.found = fnd;
      h.wall  = fnd ? 2'(bk) : 2'd0;
      h.hx    = fnd ? sat(best[0]) : 32'd0;
      h.hy    = fnd ? sat(best[1]) : 32'd0;
      h.hz    = fnd ? sat(best[2]) : 32'd0;
      h.hdist = fnd ? bd : 32'd0;
      pending_q.insert(pending_q.size(), h);
    endfunction

    // Returned transaction against the oldest expectation
    function void check_hit(hit_t got);
      hit_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, got.found); errors++;
      end
      if (got.wall !== e.wall) begin
        $error("wall_index: expected %0d, got %0d", e.wall, got.wall); errors++;
      end
      if (got.hx !== e.hx) begin
        $error("hit_x: expected %h, got %h", e.hx, got.hx); errors++;
      end
      if (got.hy !== e.hy) begin
        $error("hit_y: expected %h, got %h", e.hy, got.hy); errors++;
      end
      if (got.hz !== e.hz) begin
        $error("hit_z: expected %h, got %h", e.hz, got.hz); errors++;
      end
      if (got.hdist !== e.hdist) begin
        $error("hit_distance: expected %h, got %h", e.hdist, got.hdist); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [191:0] s_axis_tdata_i = '0;
  logic [2:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [135:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;

  wall_hit_scoreboard sb = new();
  bit                 calm;   // stretch with no idling on either side

  ray_to_arena_wall_intersect_unit DUT (.*);

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic write_reg(rawi_pkg::reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_walls(logic [31:0] v [rawi_pkg::NUM_REGS]);
    for (int i = 0; i < rawi_pkg::NUM_REGS; i++) write_reg(rawi_pkg::reg_idx_e'(i), v[i]);
  endtask

  // Drain the pipeline before touching the registers
  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic send_ray(ray_t ray);
    int n;
    n = gap();
    @(negedge clk_i);
    if (n > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= ray.opcode;
    s_axis_tdata_i  <= {ray.thru[2], ray.thru[1], ray.thru[0],
                        ray.orig[2], ray.orig[1], ray.orig[0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_ray(ray);
  endtask

  task automatic send_pts(logic [2:0] op, int ox, int oy, int oz, int tx, int ty, int tz);
    ray_t r;
    r.opcode = op;
    r.orig = '{ox, oy, oz};
    r.thru = '{tx, ty, tz};
    send_ray(r);
  endtask

  function automatic logic [31:0] local_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Random ray, mostly near the arena so that walls are really hit
  function automatic ray_t rand_ray(int span);
    ray_t r;
    int   kind;
    int   ax;
    kind = $urandom_range(0, 99);
    r.opcode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
    for (int j = 0; j < 3; j++) begin
      if (kind < 75) begin
        r.orig[j] = local_coord(span);
        r.thru[j] = r.orig[j] + local_coord(span);
      end else begin
        r.orig[j] = $urandom;
        r.thru[j] = $urandom;
      end
    end
    // zero direction on one planar axis, sometimes on both
    ax = $urandom_range(0, 1);
    if (kind >= 60 && kind < 75) r.thru[ax] = r.orig[ax];
    if (kind >= 65 && kind < 70) r.thru[1] = r.orig[1];
    return r;
  endfunction

  task automatic random_phase(int cnt, int span);
    for (int i = 0; i < cnt; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send_ray(rand_ray(span));
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    calm = 0;
  endtask

  // Receiver with random stalls
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = gap();
      @(negedge clk_i);
      if (n > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    hit_t g;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      g.found = m_axis_tuser_o;
      g.wall  = m_axis_tdata_o[1:0];
      g.hx    = m_axis_tdata_o[33:2];
      g.hy    = m_axis_tdata_o[65:34];
      g.hz    = m_axis_tdata_o[97:66];
      g.hdist = m_axis_tdata_o[129:98];
      sb.check_hit(g);
    end
  end

  // Main sequence
  initial begin
    logic [31:0] w [rawi_pkg::NUM_REGS];
    int          one;
    one = 65536;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every opcode on a plain ray, reset walls
    for (int op = 0; op < 8; op++)
      send_pts(3'(op), 0, 0, one / 2, one, one / 3, one / 2);
    // zero direction on x, and on both planar axes
    send_pts(rawi_pkg::OP_X_MAX, 0, 0, one / 2, 0, one, one / 2);
    send_pts(rawi_pkg::OP_NEAREST, 0, 0, one / 2, 0, 0, one);
    // wall behind the origin, and origin on the wall
    send_pts(rawi_pkg::OP_X_MIN, 0, 0, 0, one, 0, 0);
    send_pts(rawi_pkg::OP_X_MAX, 2 * one, 0, 0, 3 * one, 0, 0);
    // corner diagonal: equal distances, lower wall wins
    send_pts(rawi_pkg::OP_NEAREST, 0, 0, one / 2, one, one, one / 2);
    // hit above the z limit
    send_pts(rawi_pkg::OP_NEAREST, 0, 0, one / 2, one, 0, 2 * one);
    // field extremes, both directions
    send_pts(rawi_pkg::OP_X_MAX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pts(rawi_pkg::OP_Y_MIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pts(rawi_pkg::OP_NEAREST, 32'h7FFF_FFFF, 32'h8000_0000, 0,
             32'h8000_0000, 32'h7FFF_FFFF, 1);
    // steep ray: offset cap and distance saturation
    send_pts(rawi_pkg::OP_Y_MAX, 0, 0, 0, 1, 1, 32'h7FFF_FFFF);
    send_pts(rawi_pkg::OP_X_MIN, 0, 0, 0, -1, 32'h8000_0000, 32'h7FFF_FFFF);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    random_phase(100, 4 * one);
    drain();

    // Extreme walls
    w = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF};
    write_walls(w);
    random_phase(90, 4 * one);
    drain();

    // Narrow, small arena, random layout
    for (int i = 0; i < 6; i += 2) begin
      w[i]     = local_coord(3 * one);
      w[i + 1] = w[i] + $urandom_range(0, 4 * one);
    end
    write_walls(w);
    random_phase(90, 4 * one);
    drain();

    // Fully random registers, wide rays
    for (int i = 0; i < rawi_pkg::NUM_REGS; i++) w[i] = $urandom;
    write_walls(w);
    random_phase(80, 32'h3FFF_FFFF);
    drain();

    // Reversed extremes and a degenerate z band
    w = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0};
    write_walls(w);
    random_phase(40, 4 * one);
    drain();

    w = '{-3 * one, 3 * one, -one, one, -one, 2 * one};
    write_walls(w);
    random_phase(100, 4 * one);

    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rawi_pkg.sv
rtl/rawi_div.sv
rtl/rawi_sqrt.sv
rtl/ray_to_arena_wall_intersect_unit.sv
tb/tb_ray_to_arena_wall_intersect_unit.sv
